// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold expr true at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: always");

// When ante holds, cons must hold on the following edge.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next");

`endif

// ----- hdl/ksu_pkg.sv -----
// ----------------------------------------------------------------------------
// ksu_pkg
// Shared constants and types for the K-S uniformity statistic block.
// ----------------------------------------------------------------------------
package ksu_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SAMPLE_W    = 18;
  localparam int FRAC_W      = 16;
  localparam int ACC_W       = SAMPLE_W + CNT_W + 1;
  localparam int DIV_W       = ACC_W - 1;
  localparam int DIVCNT_W    = $clog2(DIV_W + 1);
  localparam int ONE_Q16     = 65536;
  localparam int STAT_MAX    = 196608;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_INS_RD   = 8'b0000_0010,
    ST_INS_CMP  = 8'b0000_0100,
    ST_INS_WR   = 8'b0000_1000,
    ST_STAT_RD  = 8'b0001_0000,
    ST_STAT_MUL = 8'b0010_0000,
    ST_STAT_ACC = 8'b0100_0000,
    ST_DIV      = 8'b1000_0000
  } state_t;

endpackage

// ----- hdl/ksu_ram.sv -----
// ----------------------------------------------------------------------------
// ksu_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ksu_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hdl/ks_uniformity_statistic.sv -----
// ----------------------------------------------------------------------------
// ks_uniformity_statistic
// One-sample Kolmogorov-Smirnov statistic against the uniform law on [0,1].
// ----------------------------------------------------------------------------
// Samples (signed Q2.16) arrive one beat at a time on start/busy; the beat
// with last high closes the set. Each kept sample is insertion-sorted into a
// single-port RAM of MAX_SAMPLES entries: each entry after its slot is
// shifted up by one read and one compare/write, then a read and compare find
// the slot and write the sample there, or a final write places it at the
// front; a dropped beat without last leaves busy low. After the closing beat
// the block walks the sorted store with one shared multiplier, reading,
// multiplying and accumulating each sample in turn, then runs a restoring
// divider by N over the DIV_W (29) bits of the dividend. The result appears
// on statistic/range_error/overflow, marked by done for exactly one cycle;
// the receiver cannot stall it, so sample it then. Samples beyond MAX_SAMPLES
// are dropped and raise overflow. No clearing pass is needed after reset:
// only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module ks_uniformity_statistic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ksu_pkg::SAMPLE_W-1:0] sample,
  input  logic                                last,
  output logic                                done,
  output logic        [ksu_pkg::SAMPLE_W-1:0] statistic,
  output logic                                range_error,
  output logic                                overflow
);

  localparam int AW = ksu_pkg::ADDR_W;
  localparam int CW = ksu_pkg::CNT_W;
  localparam int SW = ksu_pkg::SAMPLE_W;
  localparam int XW = ksu_pkg::ACC_W;
  localparam int DW = ksu_pkg::DIV_W;
  localparam int FW = ksu_pkg::FRAC_W;

  ksu_pkg::state_t state;

  // Control and working registers
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  pos;
  logic [AW-1:0]                  idx;
  logic                           range_flag;
  logic                           drop_flag;
  logic                           last_held;
  logic signed [SW-1:0]           smp;
  logic signed [XW-1:0]           ns;
  logic signed [XW-1:0]           best;
  logic [DW-1:0]                  dvd;
  logic [CW-1:0]                  rem;
  logic [ksu_pkg::DIVCNT_W-1:0]   div_cnt;

  // Store port
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [SW-1:0]     ram_wdata;
  logic [SW-1:0]     ram_rdata;
  logic signed [SW-1:0] rd_s;

  ksu_ram #(.WIDTH(SW), .DEPTH(ksu_pkg::MAX_SAMPLES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd_s = signed'(ram_rdata);
  assign busy = (state != ksu_pkg::ST_IDLE);

  logic accept;
  logic shift_up;
  assign accept   = start && !busy;
  assign shift_up = (rd_s > smp);

  // Shared arithmetic: one multiply, two offset subtracts and a divider step
  logic signed [XW-1:0] mul_a, mul_b, prod;
  logic signed [XW-1:0] off_lo, off_hi, above, below;
  logic [CW:0]          rem_sh;
  logic                 q_bit;
  logic [CW-1:0]        rem_next;

  always_comb begin
    mul_a    = signed'(XW'(count));
    mul_b    = XW'(rd_s);
    prod     = XW'(mul_a * mul_b);
    off_lo   = signed'(XW'({idx, FW'(0)}));
    off_hi   = signed'(XW'({(CW'(idx) + CW'(1)), FW'(0)}));
    above    = ns - off_lo;
    below    = off_hi - ns;
    rem_sh   = {rem, dvd[DW-1]};
    q_bit    = (rem_sh >= {1'b0, count});
    rem_next = q_bit ? CW'(rem_sh - {1'b0, count}) : CW'(rem_sh);
  end

  // Store port control
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx;
    ram_wdata = smp;
    unique case (state)
      ksu_pkg::ST_INS_RD: begin
        ram_addr = AW'(pos - CW'(1));
      end
      ksu_pkg::ST_INS_CMP: begin
        ram_we    = 1'b1;
        ram_addr  = pos[AW-1:0];
        ram_wdata = shift_up ? ram_rdata : smp;
      end
      ksu_pkg::ST_INS_WR: begin
        ram_we   = 1'b1;
        ram_addr = pos[AW-1:0];
      end
      default: begin
        ram_addr = idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ksu_pkg::ST_IDLE;
      count      <= '0;
      range_flag <= 1'b0;
      drop_flag  <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ksu_pkg::ST_IDLE: begin
          if (accept) begin
            smp       <= sample;
            last_held <= last;
            idx       <= '0;
            best      <= '0;
            if (count < CW'(ksu_pkg::MAX_SAMPLES)) begin
              // Keep the sample: flag values outside [0, 1.0]
              if (sample < 0 || sample > SW'(ksu_pkg::ONE_Q16)) begin
                range_flag <= 1'b1;
              end
              pos   <= count;
              state <= (count == '0) ? ksu_pkg::ST_INS_WR : ksu_pkg::ST_INS_RD;
            end else begin
              // Store full: drop the beat
              drop_flag <= 1'b1;
              state     <= last ? ksu_pkg::ST_STAT_RD : ksu_pkg::ST_IDLE;
            end
          end
        end
        ksu_pkg::ST_INS_RD: begin
          state <= ksu_pkg::ST_INS_CMP;
        end
        ksu_pkg::ST_INS_CMP: begin
          if (shift_up) begin
            pos   <= pos - CW'(1);
            state <= (pos == CW'(1)) ? ksu_pkg::ST_INS_WR : ksu_pkg::ST_INS_RD;
          end else begin
            count <= count + CW'(1);
            state <= last_held ? ksu_pkg::ST_STAT_RD : ksu_pkg::ST_IDLE;
          end
        end
        ksu_pkg::ST_INS_WR: begin
          count <= count + CW'(1);
          state <= last_held ? ksu_pkg::ST_STAT_RD : ksu_pkg::ST_IDLE;
        end
        ksu_pkg::ST_STAT_RD: begin
          state <= ksu_pkg::ST_STAT_MUL;
        end
        ksu_pkg::ST_STAT_MUL: begin
          ns    <= prod;
          state <= ksu_pkg::ST_STAT_ACC;
        end
        ksu_pkg::ST_STAT_ACC: begin
          // Advance the running maximum of both one-sided gaps
          priority if (above >= below && above > best) begin
            best <= above;
          end else if (below > best) begin
            best <= below;
          end
          if (CW'(idx) + CW'(1) == count) begin
            dvd     <= (above >= below && above > best) ? DW'(above) :
                       (below > best) ? DW'(below) : DW'(best);
            rem     <= '0;
            div_cnt <= '0;
            state   <= ksu_pkg::ST_DIV;
          end else begin
            idx   <= idx + AW'(1);
            state <= ksu_pkg::ST_STAT_RD;
          end
        end
        ksu_pkg::ST_DIV: begin
          rem     <= rem_next;
          dvd     <= {dvd[DW-2:0], q_bit};
          div_cnt <= div_cnt + ksu_pkg::DIVCNT_W'(1);
          if (div_cnt == ksu_pkg::DIVCNT_W'(DW - 1)) begin
            statistic    <= {dvd[SW-2:0], q_bit};
            range_error  <= range_flag;
            overflow     <= drop_flag;
            done         <= 1'b1;
            count        <= '0;
            range_flag   <= 1'b0;
            drop_flag    <= 1'b0;
            state        <= ksu_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= ksu_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/ksu_checker.sv -----
// ----------------------------------------------------------------------------
// ksu_checker
// Port-level checks for the K-S uniformity statistic block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ksu_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic [ksu_pkg::SAMPLE_W-1:0] statistic
);

  // No result follows directly on an accepted beat
  `ASSERT_NEXT(a_accept_no_done, start && !busy, !done)
  // A result is a single-cycle pulse
  `ASSERT_NEXT(a_done_pulse, done, !done)
  // A result is given only once the block is free again
  `ASSERT_ALWAYS(a_done_idle, !done || !busy)
  // The statistic never exceeds its analytic bound
  `ASSERT_ALWAYS(a_stat_bound, !done || statistic <= ksu_pkg::SAMPLE_W'(ksu_pkg::STAT_MAX))

endmodule

bind ks_uniformity_statistic ksu_checker u_ksu_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .statistic (statistic)
);
